// ===== src/ssd_pkg.sv =====
// Shared types, codes, constants and glyph functions of the serial display driver.
package ssd_pkg;

    // Operation selector on the input stream
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Update kinds
    localparam logic [1:0] KIND_NUMBER = 2'd0;
    localparam logic [1:0] KIND_RAW    = 2'd1;
    localparam logic [1:0] KIND_TEXT   = 2'd2;

    // Frame commands
    localparam logic [7:0] CMD_DATA   = 8'h40;
    localparam logic [7:0] CMD_ADDR   = 8'hC0;
    localparam logic [7:0] CMD_CTRL   = 8'h80;
    localparam logic [7:0] CTRL_ON    = 8'h08;
    localparam logic [7:0] COLON_MASK = 8'h80;

    // Glyphs for special characters
    localparam logic [7:0] GLYPH_DASH  = 8'h40;
    localparam logic [7:0] GLYPH_UNDER = 8'h08;
    localparam logic [7:0] GLYPH_BLANK = 8'h00;

    // ASCII codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;

    // Largest number shown
    localparam logic [14:0] NUM_MAX = 15'd9999;

    // Pin step codes within start and stop conditions
    localparam logic [4:0] START_DATA_HI = 5'd0;
    localparam logic [4:0] START_CLK_HI  = 5'd1;
    localparam logic [4:0] START_DATA_LO = 5'd2;
    localparam logic [4:0] START_CLK_LO  = 5'd3;
    localparam logic [4:0] STOP_CLK_LO   = 5'd0;
    localparam logic [4:0] STOP_DATA_LO  = 5'd1;
    localparam logic [4:0] STOP_CLK_HI   = 5'd2;
    localparam logic [4:0] STOP_DATA_HI  = 5'd3;

    // Pin step codes within one byte: 24 bit steps, then the ACK clock
    localparam logic [4:0] BIT_STEPS    = 5'd24;
    localparam logic [4:0] ACK_CLK_LO   = 5'd24;
    localparam logic [4:0] ACK_DATA_HI  = 5'd25;
    localparam logic [4:0] ACK_CLK_HI   = 5'd26;
    localparam logic [4:0] ACK_HOLD     = 5'd27;
    localparam logic [4:0] ACK_END      = 5'd28;

    // Phases of one data bit
    localparam logic [1:0] PH_CLK_LO = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_CLK_HI = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_BYTE,
        ST_STOP
    } state_t;

    // Command flags carried from the front end to the sequencer
    typedef struct packed {
        logic is_update;
        logic kind_ok;
        logic colon;
    } cmd_flags_t;

    function automatic logic [7:0] hex_glyph(input logic [3:0] v);
        logic [7:0] g;
        case (v)
            4'h0: g = 8'h3F;
            4'h1: g = 8'h06;
            4'h2: g = 8'h5B;
            4'h3: g = 8'h4F;
            4'h4: g = 8'h66;
            4'h5: g = 8'h6D;
            4'h6: g = 8'h7D;
            4'h7: g = 8'h07;
            4'h8: g = 8'h7F;
            4'h9: g = 8'h6F;
            4'hA: g = 8'h77;
            4'hB: g = 8'h7C;
            4'hC: g = 8'h39;
            4'hD: g = 8'h5E;
            4'hE: g = 8'h79;
            default: g = 8'h71;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] glyph_of(input logic [7:0] c);
        logic [7:0] g;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            g = hex_glyph(c[3:0]);
        end else if ((c >= CHAR_UA && c <= CHAR_UF) || (c >= CHAR_LA && c <= CHAR_LF)) begin
            g = hex_glyph(4'(c[3:0] + 4'd9));
        end else if (c == CHAR_DASH) begin
            g = GLYPH_DASH;
        end else if (c == CHAR_UNDER) begin
            g = GLYPH_UNDER;
        end else begin
            g = GLYPH_BLANK;
        end
        return g;
    endfunction

endpackage

// ===== src/ssd_front.sv =====
// Front end: accepts input transactions, classifies them and builds digit patterns.
module ssd_front #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [1:0]                 s_kind,
    input  logic signed [15:0]         s_number,
    input  logic                       s_leading_zeros,
    input  logic [31:0]                s_raw,
    input  logic [31:0]                s_text,
    input  logic                       s_colon,
    output logic                       q_push,
    input  logic                       q_ready,
    output ssd_pkg::cmd_flags_t        q_flags,
    output logic [8*DIGIT_COUNT-1:0]   q_patterns
);

    // Stage 1: clamp, split the number by 100, register
    logic        f_valid_reg, f_valid_next;
    logic        f_is_upd_reg;
    logic        f_kind_ok_reg;
    logic [1:0]  f_kind_reg;
    logic        f_lz_reg;
    logic        f_colon_reg;
    logic [6:0]  f_q1_reg;
    logic [6:0]  f_r1_reg;
    logic [31:0] f_bytes_reg;

    logic        take;
    logic [13:0] num_clamped;
    logic [26:0] prod_hundreds;
    logic [6:0]  q1;
    logic [13:0] r1_full;

    assign s_ready = !f_valid_reg || q_ready;
    assign q_push  = f_valid_reg && q_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        if (s_number[15]) begin
            num_clamped = 14'd0;
        end else if (s_number[14:0] > ssd_pkg::NUM_MAX) begin
            num_clamped = ssd_pkg::NUM_MAX[13:0];
        end else begin
            num_clamped = s_number[13:0];
        end
        // n / 100 as n * 5243 >> 19, exact below 10000
        prod_hundreds = 27'(num_clamped) * 27'd5243;
        q1            = prod_hundreds[25:19];
        r1_full       = num_clamped - 14'(q1) * 14'd100;
    end

    always_comb begin
        f_valid_next = f_valid_reg;
        if (take) begin
            f_valid_next = 1'b1;
        end else if (q_push) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f_is_upd_reg  <= (s_op == ssd_pkg::OP_UPDATE);
            f_kind_ok_reg <= (s_kind == ssd_pkg::KIND_NUMBER) || (s_kind == ssd_pkg::KIND_RAW)
                             || (s_kind == ssd_pkg::KIND_TEXT);
            f_kind_reg    <= s_kind;
            f_lz_reg      <= s_leading_zeros;
            f_colon_reg   <= s_colon;
            f_q1_reg      <= q1;
            f_r1_reg      <= r1_full[6:0];
            f_bytes_reg   <= (s_kind == ssd_pkg::KIND_RAW) ? s_raw : s_text;
        end
    end

    // Stage 2: decimal digits and glyphs, straight into the queue
    logic [14:0] prod_d3, prod_d1;
    logic [3:0]  d3, d1;
    logic [6:0]  d2_full, d0_full;
    logic [15:0] dec_vec;
    logic [3:0]  digit;
    logic [7:0]  ch, pat;
    logic        zero_run, ended;

    always_comb begin
        // x / 10 as x * 205 >> 11, exact below 100
        prod_d3 = 15'(f_q1_reg) * 15'd205;
        prod_d1 = 15'(f_r1_reg) * 15'd205;
        d3      = prod_d3[14:11];
        d1      = prod_d1[14:11];
        d2_full = f_q1_reg - 7'(d3) * 7'd10;
        d0_full = f_r1_reg - 7'(d1) * 7'd10;
        dec_vec = {d3, d2_full[3:0], d1, d0_full[3:0]};

        zero_run   = 1'b1;
        ended      = 1'b0;
        digit      = 4'd0;
        ch         = 8'h00;
        pat        = 8'h00;
        q_patterns = '0;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            // leftmost digit holds the highest decimal place
            if (DIGIT_COUNT - 1 - i < 4) begin
                digit = 4'(dec_vec >> (4 * (DIGIT_COUNT - 1 - i)));
            end else begin
                digit = 4'd0;
            end
            zero_run = zero_run && (digit == 4'd0);

            if (i < 4) begin
                ch = 8'(f_bytes_reg >> (8 * i));
            end else begin
                ch = ssd_pkg::CHAR_NUL;
            end
            ended = ended || (ch == ssd_pkg::CHAR_NUL);

            case (f_kind_reg)
                ssd_pkg::KIND_NUMBER: begin
                    if (!f_lz_reg && zero_run && (i < DIGIT_COUNT - 1)) begin
                        pat = ssd_pkg::GLYPH_BLANK;
                    end else begin
                        pat = ssd_pkg::hex_glyph(digit);
                    end
                end
                ssd_pkg::KIND_RAW: pat = ch;
                default: pat = ended ? ssd_pkg::GLYPH_BLANK : ssd_pkg::glyph_of(ch);
            endcase
            q_patterns[8*i +: 8] = pat;
        end
    end

    assign q_flags.is_update = f_is_upd_reg;
    assign q_flags.kind_ok   = f_kind_ok_reg;
    assign q_flags.colon     = f_colon_reg;

endmodule

// ===== src/ssd_queue.sv =====
// Short FIFO between the front end and the frame sequencer.
module ssd_queue #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== src/ssd_back.sv =====
// Frame sequencer: applies updates, steps the serial frame and registers results.
module ssd_back #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  ssd_pkg::cmd_flags_t      q_flags,
    input  logic [8*DIGIT_COUNT-1:0] q_patterns,
    input  logic [2:0]               brightness,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_data
);

    localparam int BYTE_W = $clog2(DIGIT_COUNT + 3);
    localparam logic [BYTE_W-1:0] BYTE_DATA  = BYTE_W'(0);
    localparam logic [BYTE_W-1:0] BYTE_LAST_DIGIT = BYTE_W'(DIGIT_COUNT + 1);
    localparam logic [BYTE_W-1:0] BYTE_CTRL  = BYTE_W'(DIGIT_COUNT + 2);

    ssd_pkg::state_t state_reg, state_next;
    logic [4:0]        step_reg, step_next;
    logic [1:0]        ph_reg, ph_next;
    logic [2:0]        bit_reg, bit_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              clk_reg, clk_next;
    logic              dat_reg, dat_next;
    logic [8*DIGIT_COUNT-1:0] pat_reg;
    logic              colon_reg;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg, m_data_next;

    logic       do_item, load, acc, done;
    logic [7:0] cur_byte;

    assign do_item = q_valid && (!m_valid_reg || m_ready);
    assign q_pop   = do_item;
    assign load    = do_item && q_flags.is_update && q_flags.kind_ok && (state_reg == ssd_pkg::ST_IDLE);

    // Byte currently on the wire
    always_comb begin
        cur_byte = 8'h00;
        if (byte_reg == BYTE_DATA) begin
            cur_byte = ssd_pkg::CMD_DATA;
        end else if (byte_reg == BYTE_CTRL) begin
            cur_byte = ssd_pkg::CMD_CTRL | ssd_pkg::CTRL_ON | {5'b0, brightness};
        end else if (byte_reg == BYTE_W'(1)) begin
            cur_byte = ssd_pkg::CMD_ADDR;
        end else begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                if (byte_reg == BYTE_W'(i + 2)) begin
                    cur_byte = pat_reg[8*i +: 8];
                    if (i == 1 && colon_reg) begin
                        cur_byte = cur_byte | ssd_pkg::COLON_MASK;
                    end
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        ph_next    = ph_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        clk_next   = clk_reg;
        dat_next   = dat_reg;
        acc        = 1'b0;
        done       = 1'b0;

        if (do_item && q_flags.is_update) begin
            if (load) begin
                state_next = ssd_pkg::ST_START;
                step_next  = '0;
                byte_next  = BYTE_DATA;
                acc        = 1'b1;
            end
        end else if (do_item) begin
            unique case (state_reg)
                ssd_pkg::ST_IDLE: begin
                end
                ssd_pkg::ST_START: begin
                    case (step_reg)
                        ssd_pkg::START_DATA_HI: dat_next = 1'b1;
                        ssd_pkg::START_CLK_HI:  clk_next = 1'b1;
                        ssd_pkg::START_DATA_LO: dat_next = 1'b0;
                        default:                clk_next = 1'b0;
                    endcase
                    if (step_reg == ssd_pkg::START_CLK_LO) begin
                        state_next = ssd_pkg::ST_BYTE;
                        step_next  = '0;
                        ph_next    = ssd_pkg::PH_CLK_LO;
                        bit_next   = '0;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
                ssd_pkg::ST_BYTE: begin
                    if (step_reg < ssd_pkg::BIT_STEPS) begin
                        case (ph_reg)
                            ssd_pkg::PH_CLK_LO: clk_next = 1'b0;
                            ssd_pkg::PH_DATA:   dat_next = cur_byte[bit_reg];
                            default:            clk_next = 1'b1;
                        endcase
                        if (ph_reg == ssd_pkg::PH_CLK_HI) begin
                            ph_next  = ssd_pkg::PH_CLK_LO;
                            bit_next = bit_reg + 1'b1;
                        end else begin
                            ph_next = ph_reg + 1'b1;
                        end
                    end else begin
                        case (step_reg) inside
                            ssd_pkg::ACK_CLK_LO, ssd_pkg::ACK_END: clk_next = 1'b0;
                            ssd_pkg::ACK_DATA_HI:                  dat_next = 1'b1;
                            ssd_pkg::ACK_CLK_HI:                   clk_next = 1'b1;
                            default: begin
                            end
                        endcase
                    end
                    if (step_reg == ssd_pkg::ACK_END) begin
                        step_next = '0;
                        ph_next   = ssd_pkg::PH_CLK_LO;
                        bit_next  = '0;
                        // each command part ends after its last byte
                        if (byte_reg == BYTE_DATA || byte_reg == BYTE_LAST_DIGIT
                            || byte_reg == BYTE_CTRL) begin
                            state_next = ssd_pkg::ST_STOP;
                        end else begin
                            byte_next = byte_reg + 1'b1;
                        end
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
                ssd_pkg::ST_STOP: begin
                    case (step_reg)
                        ssd_pkg::STOP_CLK_LO:  clk_next = 1'b0;
                        ssd_pkg::STOP_DATA_LO: dat_next = 1'b0;
                        ssd_pkg::STOP_CLK_HI:  clk_next = 1'b1;
                        default:               dat_next = 1'b1;
                    endcase
                    if (step_reg == ssd_pkg::STOP_DATA_HI) begin
                        step_next = '0;
                        if (byte_reg == BYTE_CTRL) begin
                            state_next = ssd_pkg::ST_IDLE;
                            done       = 1'b1;
                        end else begin
                            state_next = ssd_pkg::ST_START;
                            byte_next  = byte_reg + 1'b1;
                        end
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (do_item) begin
            m_valid_next = 1'b1;
            m_data_next  = {3'b000, done, acc, (state_next != ssd_pkg::ST_IDLE),
                            dat_next, clk_next};
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ssd_pkg::ST_IDLE;
            step_reg    <= '0;
            ph_reg      <= ssd_pkg::PH_CLK_LO;
            bit_reg     <= '0;
            byte_reg    <= BYTE_DATA;
            clk_reg     <= 1'b1;
            dat_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            ph_reg      <= ph_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            clk_reg     <= clk_next;
            dat_reg     <= dat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (load) begin
            pat_reg   <= q_patterns;
            colon_reg <= q_flags.colon;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/seven_segment_serial_display_driver_top.sv =====
// Top level of the two-wire seven-segment display driver.
// Each input transaction is either a bit-time tick or a display update; every one
// yields exactly one result transaction with the clock and data line levels, busy,
// accepted and frame_done. The block takes one transaction per clock cycle
// sustained while m_tready does not hold it back. An accepted input loads the front
// register at the accepting edge, then passes the command FIFO and the result register
// before m_tvalid rises; the FIFO lets either side stall on its own.
// An accepted update starts a refresh frame that takes 111 + 29 * DIGIT_COUNT ticks
// (227 for four digits); the frame sequencer carries out one pin step per tick and
// rejects updates until the frame ends. Brightness is read live by the sequencer
// and should be written only while the block is idle.
module seven_segment_serial_display_driver_top #(
    parameter int DIGIT_COUNT = 4,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] number_value, [16] leading_zeros, [48:17] raw_segments,
    // [80:49] text_chars, [81] colon_on, [87:82] zero
    input  logic [87:0] s_tdata,
    // [0] operation, [2:1] update_kind
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] clock_level, [1] data_level, [2] busy_res, [3] accepted,
    // [4] frame_done, [7:5] zero
    output logic [7:0]  m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data
);

    localparam int PAT_W = 8 * DIGIT_COUNT;
    localparam int CMD_W = PAT_W + $bits(ssd_pkg::cmd_flags_t);

    logic [2:0] brightness_reg, brightness_next;

    always_comb begin
        brightness_next = cfg_wr_en ? cfg_wr_data : brightness_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= 3'd7;
        end else begin
            brightness_reg <= brightness_next;
        end
    end

    logic                f_push, f_ready;
    ssd_pkg::cmd_flags_t f_flags, b_flags;
    logic [PAT_W-1:0]    f_patterns, b_patterns;
    logic                b_valid, b_pop;
    logic [CMD_W-1:0]    b_cmd;

    ssd_front #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_tvalid),
        .s_ready         (s_tready),
        .s_op            (s_tuser[0]),
        .s_kind          (s_tuser[2:1]),
        .s_number        (s_tdata[15:0]),
        .s_leading_zeros (s_tdata[16]),
        .s_raw           (s_tdata[48:17]),
        .s_text          (s_tdata[80:49]),
        .s_colon         (s_tdata[81]),
        .q_push          (f_push),
        .q_ready         (f_ready),
        .q_flags         (f_flags),
        .q_patterns      (f_patterns)
    );

    ssd_queue #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_push),
        .in_ready  (f_ready),
        .in_data   ({f_flags, f_patterns}),
        .out_valid (b_valid),
        .out_ready (b_pop),
        .out_data  (b_cmd)
    );

    assign b_flags    = b_cmd[CMD_W-1:PAT_W];
    assign b_patterns = b_cmd[PAT_W-1:0];

    ssd_back #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (b_valid),
        .q_pop      (b_pop),
        .q_flags    (b_flags),
        .q_patterns (b_patterns),
        .brightness (brightness_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (m_tdata)
    );

endmodule
